// File: hdl/ptw_pkg.sv
package ptw_pkg;

	localparam int WORD_W = 32;
	localparam int VA_W   = 16;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, T_RD, T_CHK, T_ADV,
		SR_ENTER, SR_RD, SR_CHK, SR_NEXT, SR_DOWN, SR_RET, SR_UP,
		F_DEC, E_RDREF, E_CHK, E_CRD, E_CWR, E_CLR,
		F_FILL, F_LWR, F_END, D_ACC, D_RD, S_MOD, S_OUT
	} state_t;

	typedef enum logic [1:0] {R_GO_ON, R_EMPTY, R_FARTHER, R_STOP} res_t;

	typedef enum logic [1:0] {RT_TRANS, RT_SEARCH, RT_EVICT} ret_t;

endpackage

// File: hdl/page_table_walk_with_eviction_top.sv
// Page table walker with eviction, one word access per request.
// The request channel (req_valid, req_stall) carries action, virtual_address and
// write_value; the response channel (rsp_valid, rsp_stall) returns ok and read_value.
// One request is handled at a time: req_stall stays high from acceptance until the
// response has been taken, so the rate is set by the single sequencer and its one
// read and one write port on each of the physical memory and the swap store.
// A rejected address goes from S_IDLE straight to S_OUT with ok low. A walk that hits
// passes T_RD, T_CHK and T_ADV for each table level, then D_ACC, D_RD for a read, and
// S_OUT. A fault adds a search of the whole table tree, a fill of the new frame and,
// when a page is evicted, a save of it to the swap store. An entry that is not below
// FRAME_COUNT is reduced by a reciprocal multiplication with one correction step.
// After reset both memories are cleared by a pass of the clear counter, with req_stall high.
// While rsp_stall is high the response is held unchanged and no request is taken.
module page_table_walk_with_eviction_top #(
	parameter int OFFSET_BITS  = 4,
	parameter int TABLE_LEVELS = 2,
	parameter int FRAME_COUNT  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              action,
	input  logic        [ptw_pkg::VA_W-1:0]   virtual_address,
	input  logic signed [ptw_pkg::WORD_W-1:0] write_value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              ok,
	output logic signed [ptw_pkg::WORD_W-1:0] read_value
);
	import ptw_pkg::*;

	localparam int OB       = OFFSET_BITS;
	localparam int TL       = TABLE_LEVELS;
	localparam int FC       = FRAME_COUNT;
	localparam int VB       = OB * (TL + 1);
	localparam int PB       = OB * TL;
	localparam int FB       = $clog2(FC);
	localparam int PAW      = FB + OB;
	localparam int PM_DEPTH = FC * (2 ** OB);
	localparam int SLW      = $clog2(TL + 1);
	localparam int CW       = (VB > PAW) ? VB : PAW;
	localparam logic [2*WORD_W-1:0] RECIP = ((2*WORD_W)'(1) << WORD_W) / (2*WORD_W)'(FC);

	state_t state_q, state_d;
	logic [CW-1:0] clr_q;

	logic              act_q;
	logic [VB-1:0]     va_q;
	logic [WORD_W-1:0] wv_q;
	logic [SLW-1:0]    tl_q, sl_q;
	logic [FB-1:0]     cur_q, chf_q, fr_q, top_q, empty_q;
	logic [PB-1:0]     vp_q, best_dist_q, best_page_q;
	logic [PAW-1:0]    best_ref_q;
	logic [OB-1:0]     cnt_q;
	res_t              res_q;
	ret_t              ret_q;
	logic [WORD_W-1:0]   mv_q, mr_q;
	logic [2*WORD_W-1:0] prod_q;
	logic [1:0]          mcnt_q;
	logic              ok_q;
	logic [WORD_W-1:0] rv_q;

	logic [FB-1:0] stk_frame_q [TL+1];
	logic [OB-1:0] stk_i_q     [TL+1];
	logic          stk_empty_q [TL+1];
	logic [PB-1:0] stk_vp_q    [TL+1];

	logic [WORD_W-1:0] pm_mem [PM_DEPTH];
	logic [WORD_W-1:0] sw_mem [2 ** VB];
	logic [WORD_W-1:0] pm_rdata_q, sw_rdata_q;
	logic              pm_we, sw_we;
	logic [PAW-1:0]    pm_wa, pm_ra;
	logic [VB-1:0]     sw_wa, sw_ra;
	logic [WORD_W-1:0] pm_wd, sw_wd;

	logic              rej;
	logic [PB-1:0]     page;
	logic [OB-1:0]     idx_tl, off;
	logic [PAW-1:0]    ea;
	logic [WORD_W-1:0] v_in;
	logic              v_zero, v_small;
	logic [FB-1:0]     v_fr;
	logic [FB-1:0]     sf;
	logic [OB-1:0]     si;
	logic              se;
	logic [PB-1:0]     svp;
	logic [PB+OB-1:0]  vp_cat;
	logic [PB-1:0]     d, cdist;
	logic [PB:0]       dc;
	logic              farther;
	logic [WORD_W-1:0] mfix;
	logic [FB-1:0]     rnext;
	logic              is_table;

	assign rej      = (virtual_address >> VB) != '0;
	assign page     = va_q[VB-1:OB];
	assign idx_tl   = OB'(va_q >> (PB - OB * int'(tl_q)));
	assign off      = va_q[OB-1:0];
	assign ea       = {cur_q, idx_tl};
	assign v_in     = pm_rdata_q;
	assign v_zero   = v_in == '0;
	assign v_small  = v_in < WORD_W'(FC);
	assign v_fr     = FB'(v_in);
	assign sf       = stk_frame_q[sl_q];
	assign si       = stk_i_q[sl_q];
	assign se       = stk_empty_q[sl_q];
	assign svp      = stk_vp_q[sl_q];
	assign vp_cat   = {svp, si};
	assign d        = (page > vp_q) ? (page - vp_q) : (vp_q - page);
	assign dc       = {1'b1, {PB{1'b0}}} - {1'b0, d};
	assign cdist    = ({1'b0, d} < dc) ? d : dc[PB-1:0];
	assign farther  = cdist > best_dist_q;
	assign mfix     = (mr_q >= WORD_W'(FC)) ? mr_q - WORD_W'(FC) : mr_q;
	assign rnext    = FB'(mfix);
	assign is_table = tl_q != SLW'(TL - 1);

	assign req_stall  = state_q != S_IDLE;
	assign rsp_valid  = state_q == S_OUT;
	assign ok         = ok_q;
	assign read_value = rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pm_we   = 1'b0;
		pm_wa   = ea;
		pm_wd   = '0;
		pm_ra   = ea;
		sw_we   = 1'b0;
		sw_wa   = {page, cnt_q};
		sw_wd   = '0;
		sw_ra   = {page, cnt_q};
		unique case (state_q)
			S_CLR: begin
				pm_wa = PAW'(clr_q);
				pm_we = PAW'(clr_q) < PAW'(PM_DEPTH - 1) || PAW'(clr_q) == PAW'(PM_DEPTH - 1);
				sw_we = 1'b1;
				sw_wa = VB'(clr_q);
				if (&clr_q) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = rej ? S_OUT : T_RD;
				end
			end
			T_RD: state_d = T_CHK;
			T_CHK: begin
				if (v_zero) begin
					state_d = SR_ENTER;
				end else begin
					state_d = v_small ? T_ADV : S_MOD;
				end
			end
			T_ADV: state_d = (tl_q == SLW'(TL - 1)) ? D_ACC : T_RD;
			SR_ENTER: state_d = (sl_q == SLW'(TL)) ? SR_RET : SR_RD;
			SR_RD: begin
				pm_ra   = {sf, si};
				state_d = SR_CHK;
			end
			SR_CHK: begin
				if (v_zero) begin
					state_d = SR_NEXT;
				end else begin
					state_d = v_small ? SR_DOWN : S_MOD;
				end
			end
			SR_DOWN: state_d = SR_ENTER;
			SR_NEXT: state_d = (&si) ? SR_RET : SR_RD;
			SR_RET: state_d = (sl_q == '0) ? F_DEC : SR_UP;
			SR_UP: begin
				unique case (res_q)
					R_STOP: state_d = SR_RET;
					R_EMPTY: begin
						pm_we   = 1'b1;
						pm_wa   = {sf, si};
						state_d = SR_RET;
					end
					default: state_d = SR_NEXT;
				endcase
			end
			F_DEC: begin
				if (empty_q != '0 || top_q < FB'(FC - 1)) begin
					state_d = F_FILL;
				end else begin
					state_d = E_RDREF;
				end
			end
			E_RDREF: begin
				pm_ra   = best_ref_q;
				state_d = E_CHK;
			end
			E_CHK: state_d = v_small ? E_CRD : S_MOD;
			E_CRD: begin
				pm_ra   = {chf_q, cnt_q};
				state_d = E_CWR;
			end
			E_CWR: begin
				sw_we   = 1'b1;
				sw_wa   = {best_page_q, cnt_q};
				sw_wd   = pm_rdata_q;
				state_d = (&cnt_q) ? E_CLR : E_CRD;
			end
			E_CLR: begin
				pm_we   = 1'b1;
				pm_wa   = best_ref_q;
				state_d = F_FILL;
			end
			F_FILL: begin
				if (is_table) begin
					pm_we   = 1'b1;
					pm_wa   = {chf_q, cnt_q};
					state_d = (&cnt_q) ? F_END : F_FILL;
				end else begin
					state_d = F_LWR;
				end
			end
			F_LWR: begin
				pm_we   = 1'b1;
				pm_wa   = {chf_q, cnt_q};
				pm_wd   = sw_rdata_q;
				state_d = (&cnt_q) ? F_END : F_FILL;
			end
			F_END: begin
				pm_we   = 1'b1;
				pm_wd   = WORD_W'(chf_q);
				state_d = T_ADV;
			end
			D_ACC: begin
				pm_ra = {cur_q, off};
				pm_wa = {cur_q, off};
				if (act_q) begin
					pm_we   = 1'b1;
					pm_wd   = wv_q;
					state_d = S_OUT;
				end else begin
					state_d = D_RD;
				end
			end
			D_RD: state_d = S_OUT;
			S_MOD: begin
				if (mcnt_q == 2'd2) begin
					unique case (ret_q)
						RT_TRANS:  state_d = T_ADV;
						RT_SEARCH: state_d = SR_DOWN;
						default:   state_d = E_CRD;
					endcase
				end
			end
			S_OUT: begin
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					act_q <= action;
					va_q  <= VB'(virtual_address);
					wv_q  <= write_value;
					tl_q  <= '0;
					cur_q <= '0;
					ok_q  <= !rej;
					rv_q  <= '0;
				end
			end
			T_CHK: begin
				if (v_zero) begin
					top_q       <= '0;
					empty_q     <= '0;
					best_dist_q <= '0;
					best_page_q <= '0;
					best_ref_q  <= '0;
					fr_q        <= '0;
					sl_q        <= '0;
					vp_q        <= '0;
				end else if (v_small) begin
					chf_q <= v_fr;
				end else begin
					mv_q   <= v_in;
					mcnt_q <= '0;
					ret_q  <= RT_TRANS;
				end
			end
			T_ADV: begin
				cur_q <= chf_q;
				tl_q  <= tl_q + 1'b1;
			end
			SR_ENTER: begin
				if (fr_q > top_q) begin
					top_q <= fr_q;
				end
				if (sl_q == SLW'(TL)) begin
					if (farther) begin
						best_dist_q <= cdist;
						best_page_q <= vp_q;
						res_q       <= R_FARTHER;
					end else begin
						res_q <= R_GO_ON;
					end
				end else begin
					stk_frame_q[sl_q] <= fr_q;
					stk_i_q[sl_q]     <= '0;
					stk_empty_q[sl_q] <= 1'b1;
					stk_vp_q[sl_q]    <= vp_q;
				end
			end
			SR_CHK: begin
				if (!v_zero) begin
					stk_empty_q[sl_q] <= 1'b0;
					if (v_small) begin
						chf_q <= v_fr;
					end else begin
						mv_q   <= v_in;
						mcnt_q <= '0;
						ret_q  <= RT_SEARCH;
					end
				end
			end
			SR_DOWN: begin
				fr_q <= chf_q;
				vp_q <= vp_cat[PB-1:0];
				sl_q <= sl_q + 1'b1;
			end
			SR_NEXT: begin
				if (&si) begin
					if (se && sf != cur_q) begin
						empty_q <= sf;
						res_q   <= R_EMPTY;
					end else begin
						res_q <= R_GO_ON;
					end
				end else begin
					stk_i_q[sl_q] <= si + 1'b1;
				end
			end
			SR_RET: begin
				if (sl_q != '0) begin
					sl_q <= sl_q - 1'b1;
				end
			end
			SR_UP: begin
				if (res_q == R_EMPTY) begin
					res_q <= R_STOP;
				end else if (res_q == R_FARTHER) begin
					best_ref_q <= {sf, si};
				end
			end
			F_DEC: begin
				cnt_q <= '0;
				if (empty_q != '0) begin
					chf_q <= empty_q;
				end else if (top_q < FB'(FC - 1)) begin
					chf_q <= top_q + 1'b1;
				end
			end
			E_CHK: begin
				if (v_small) begin
					chf_q <= v_fr;
					cnt_q <= '0;
				end else begin
					mv_q   <= v_in;
					mcnt_q <= '0;
					ret_q  <= RT_EVICT;
				end
			end
			E_CWR: cnt_q <= cnt_q + 1'b1;
			F_FILL: begin
				if (is_table) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			F_LWR: cnt_q <= cnt_q + 1'b1;
			D_RD: rv_q <= pm_rdata_q;
			S_MOD: begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == 2'd0) begin
					prod_q <= (2*WORD_W)'(mv_q) * RECIP;
				end else if (mcnt_q == 2'd1) begin
					mr_q <= mv_q - prod_q[2*WORD_W-1:WORD_W] * WORD_W'(FC);
				end else begin
					chf_q <= rnext;
					cnt_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			pm_mem[pm_wa] <= pm_wd;
		end
		pm_rdata_q <= pm_mem[pm_ra];
	end

	always_ff @(posedge clk) begin
		if (sw_we) begin
			sw_mem[sw_wa] <= sw_wd;
		end
		sw_rdata_q <= sw_mem[sw_ra];
	end

	a_reject_answers: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && rej |=> rsp_valid && !ok)
		else $error("A rejected address did not answer at once with ok low.");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && act_q |-> read_value == '0)
		else $error("A write returned a non-zero read value.");

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_ADV |-> chf_q < FB'(FC - 1) || chf_q == FB'(FC - 1))
		else $error("A walk stepped to a frame beyond the physical memory.");

	a_unwind_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SR_UP |-> sl_q < SLW'(TL))
		else $error("The search unwound to a level that holds no table.");

endmodule
